### src/bfr_pkg.sv
package bfr_pkg;

   // Accumulator size in bits (40 to 128)
   localparam int ACC_BITS = 64;

   // Held-bit counter is wide enough for ACC_BITS and for the 7-bit result field
   localparam int CNT_BITS = $clog2(ACC_BITS + 1);
   localparam int HELD_W = (CNT_BITS > 7) ? CNT_BITS : 7;

   // Extraction window: accumulator followed by 32 zero bits for end-of-data padding
   localparam int WIN_W = ACC_BITS + 32;
   localparam int SH_W = $clog2(WIN_W + 1);

   localparam int FIELD_W = 32;
   localparam int MAX_COUNT = 32;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_GET   = 2'd1,
      OP_SHOW  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NEED_MORE = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Classified request as it travels through the queue
   typedef struct packed {
      logic       is_push;
      logic       read_out;
      logic       advance;
      logic [7:0] data;
      logic       last;
      logic [5:0] count;
   } entry_type;

endpackage

### src/bfr_front.sv
module bfr_front (
   input  logic [1:0]          req_type,
   input  logic [7:0]          req_byte_in,
   input  logic                req_last_byte,
   input  logic [5:0]          req_bit_count,
   output bfr_pkg::entry_type  entry
);

   bfr_pkg::op_type op;

   assign op = bfr_pkg::op_type'(req_type);

   // Decode the request kind and clamp the bit count
   always_comb begin
      entry.data  = req_byte_in;
      entry.last  = req_last_byte;
      entry.count = (req_bit_count > 6'(bfr_pkg::MAX_COUNT)) ?
                    6'(bfr_pkg::MAX_COUNT) : req_bit_count;
      unique case (op)
         bfr_pkg::OP_PUSH: begin
            entry.is_push  = 1'b1;
            entry.read_out = 1'b0;
            entry.advance  = 1'b0;
         end
         bfr_pkg::OP_GET: begin
            entry.is_push  = 1'b0;
            entry.read_out = 1'b1;
            entry.advance  = 1'b1;
         end
         bfr_pkg::OP_SHOW: begin
            entry.is_push  = 1'b0;
            entry.read_out = 1'b1;
            entry.advance  = 1'b0;
         end
         bfr_pkg::OP_FLUSH: begin
            entry.is_push  = 1'b0;
            entry.read_out = 1'b0;
            entry.advance  = 1'b1;
         end
         default: begin
            entry.is_push  = 1'b0;
            entry.read_out = 1'b0;
            entry.advance  = 1'b0;
         end
      endcase
   end

endmodule

### src/bfr_queue.sv
module bfr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bfr_pkg::entry_type  wr_entry,
   output logic                full,
   input  logic                pop,
   output logic                rd_valid,
   output bfr_pkg::entry_type  rd_entry
);

   bfr_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

### src/bfr_back.sv
module bfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                entry_valid,
   input  bfr_pkg::entry_type  entry,
   output logic                entry_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_field_bits,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_bit_position,
   output logic [6:0]          rsp_bits_held
);

   localparam int HW = bfr_pkg::HELD_W;
   localparam int AW = bfr_pkg::ACC_BITS;

   logic [AW-1:0]         acc_ff, acc_in;
   logic [HW-1:0]         held_ff, held_in;
   logic                  ended_ff, ended_in;
   logic [31:0]           consumed_ff, consumed_in;

   logic                  rsp_valid_ff;
   logic [31:0]           field_ff, field_in;
   bfr_pkg::status_type   status_ff, status_in;

   logic [HW-1:0]            n_ext;
   logic                     enough;
   logic [bfr_pkg::SH_W-1:0] shift;
   logic [bfr_pkg::WIN_W-1:0] window;
   logic [31:0]              mask;

   assign entry_pop = entry_valid && (!rsp_valid_ff || !rsp_stall);

   // Field extraction: window shift covers both the normal and the zero-padded case
   always_comb begin
      n_ext  = HW'(entry.count);
      enough = (held_ff >= n_ext);
      shift  = bfr_pkg::SH_W'(held_ff) + bfr_pkg::SH_W'(bfr_pkg::MAX_COUNT)
               - bfr_pkg::SH_W'(entry.count);
      window = {acc_ff, 32'd0} >> shift;
      mask   = 32'hFFFF_FFFF >> (6'(bfr_pkg::MAX_COUNT) - entry.count);
   end

   // Execute one beat against the accumulator state
   always_comb begin
      acc_in      = acc_ff;
      held_in     = held_ff;
      ended_in    = ended_ff;
      consumed_in = consumed_ff;
      field_in    = 32'd0;
      status_in   = bfr_pkg::ST_OK;
      if (entry.is_push) begin
         if (held_ff > HW'(AW - 8)) begin
            status_in = bfr_pkg::ST_FULL;
         end else begin
            acc_in  = {acc_ff[AW-9:0], entry.data};
            held_in = held_ff + HW'(8);
            if (entry.last) begin
               ended_in = 1'b1;
            end
         end
      end else if (enough || ended_ff) begin
         if (entry.read_out) begin
            field_in = window[31:0] & mask;
         end
         if (entry.advance) begin
            held_in     = enough ? (held_ff - n_ext) : '0;
            consumed_in = consumed_ff + 32'(entry.count);
         end
      end else begin
         status_in = bfr_pkg::ST_NEED_MORE;
      end
   end

   // State and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         ended_ff     <= 1'b0;
         consumed_ff  <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (entry_pop) begin
            acc_ff       <= acc_in;
            held_ff      <= held_in;
            ended_ff     <= ended_in;
            consumed_ff  <= consumed_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         field_ff  <= field_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_field_bits   = field_ff;
   assign rsp_status       = status_ff;
   assign rsp_bit_position = consumed_ff;
   assign rsp_bits_held    = held_ff[6:0];

endmodule

### src/bitstream_field_reader.sv
// MSB-first bitstream field reader.
// Request channel (req_*): one beat per request. req_type selects push byte,
// get, show or flush; req_byte_in/req_last_byte apply to push, req_bit_count
// (clamped to 32) to the other three. A beat is taken when req_valid is high
// and req_stall is low.
// Response channel (rsp_*): exactly one beat per request, in request order,
// carrying the field bits, a status (ok, need more bytes, accumulator full),
// the running bit position and the bits still held.
// Flow: a taken request waits in the queue, is executed into the response
// register once the response side can accept it, and its response is then
// held steady until it is taken.
// Throughput: one request per cycle while neither side stalls; the bit accumulator,
// held count and bit position update together with one barrel shift and mask.
// A two-entry queue sits between request decode and execution, so requests
// keep flowing while a finished response waits; req_stall rises only when
// that queue is full. While rsp_stall is high the response holds steady.
// Reset clears the accumulator, held count, end-of-stream flag, bit position
// and both queue and response valid state.
module bitstream_field_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_byte_in,
   input  logic        req_last_byte,
   input  logic [5:0]  req_bit_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_field_bits,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_bit_position,
   output logic [6:0]  rsp_bits_held
);

   bfr_pkg::entry_type front_entry;
   bfr_pkg::entry_type queue_entry;
   logic               queue_full;
   logic               queue_valid;
   logic               queue_pop;
   logic               req_take;

   assign req_stall = queue_full;
   assign req_take  = req_valid && !queue_full;

   // Decode stage
   bfr_front u_front (
      .req_type      (req_type),
      .req_byte_in   (req_byte_in),
      .req_last_byte (req_last_byte),
      .req_bit_count (req_bit_count),
      .entry         (front_entry)
   );

   // Decoupling queue
   bfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_take),
      .wr_entry (front_entry),
      .full     (queue_full),
      .pop      (queue_pop),
      .rd_valid (queue_valid),
      .rd_entry (queue_entry)
   );

   // Execution stage
   bfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .entry_valid      (queue_valid),
      .entry            (queue_entry),
      .entry_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_field_bits   (rsp_field_bits),
      .rsp_status       (rsp_status),
      .rsp_bit_position (rsp_bit_position),
      .rsp_bits_held    (rsp_bits_held)
   );

`ifndef SYNTHESIS
   // Non-ok answers never carry field bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bfr_pkg::ST_OK) |-> (rsp_field_bits == 32'd0))
      else $error("field bits set on a non-ok response");

   // Need-more only when fewer than 32 bits are held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bfr_pkg::ST_NEED_MORE) |-> (rsp_bits_held < 7'd32))
      else $error("need-more reported with enough bits held");

   // No response beat right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Queue never pops while empty
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> queue_valid)
      else $error("queue popped while empty");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int QUIET_LIMIT = 2000;

   // Expected response fields for one request
   typedef struct {
      logic [31:0]         field_bits;
      bfr_pkg::status_type status;
      logic [31:0]         bit_position;
      logic [6:0]          bits_held;
   } reading_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = bfr_pkg::OP_PUSH;
   logic [7:0]  req_byte_in = '0;
   logic        req_last_byte = 1'b0;
   logic [5:0]  req_bit_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_field_bits;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_bit_position;
   logic [6:0]  rsp_bits_held;

   // Shadow of the reader state, advanced as each request beat is taken
   logic [bfr_pkg::ACC_BITS-1:0] acc_model = '0;
   int                           held_model = 0;
   logic                         ended_model = 1'b0;
   logic [31:0]                  position_model = '0;

   reading_type pending_readings[$];
   int          mismatches = 0;
   int          send_gap_pct = 24;
   int          recv_gap_pct = 67;
   int          hold_request_seq = 0;
   int          hold_seen_seq = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   bitstream_field_reader u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_byte_in     (req_byte_in),
      .req_last_byte   (req_last_byte),
      .req_bit_count   (req_bit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_field_bits  (rsp_field_bits),
      .rsp_status      (rsp_status),
      .rsp_bit_position(rsp_bit_position),
      .rsp_bits_held   (rsp_bits_held)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reader behavior: updates the shadow state and returns the response
   function automatic reading_type apply_request(bfr_pkg::op_type op, logic [7:0] data,
                                                 logic mark_last, logic [5:0] count);
      reading_type                     r;
      int                              n;
      int                              shift;
      logic [bfr_pkg::ACC_BITS+31:0]   window;
      logic [31:0]                     value;
      bfr_pkg::status_type             st;
      n = (count > 32) ? 32 : int'(count);
      value = '0;
      st = bfr_pkg::ST_OK;
      if (op == bfr_pkg::OP_PUSH) begin
         if (held_model + 8 > bfr_pkg::ACC_BITS) begin
            st = bfr_pkg::ST_FULL;
         end else begin
            acc_model = {acc_model[bfr_pkg::ACC_BITS-9:0], data};
            held_model += 8;
            if (mark_last) ended_model = 1'b1;
         end
      end else if (held_model >= n || ended_model) begin
         // held bits followed by 32 zero bits cover the padded case too
         window = {acc_model, 32'b0};
         shift = held_model + 32 - n;
         value = 32'((window >> shift) & ((64'd1 << n) - 64'd1));
         if (op == bfr_pkg::OP_FLUSH) value = '0;
         if (op != bfr_pkg::OP_SHOW) begin
            held_model = (held_model >= n) ? held_model - n : 0;
            position_model += 32'(n);
         end
      end else begin
         st = bfr_pkg::ST_NEED_MORE;
      end
      r.field_bits = value;
      r.status = st;
      r.bit_position = position_model;
      r.bits_held = 7'(held_model);
      return r;
   endfunction

   // Offer one request beat, with random idle cycles ahead of it
   task automatic send_item(bfr_pkg::op_type op, logic [7:0] data, logic mark_last,
                            logic [5:0] count);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_byte_in <= data;
      req_last_byte <= mark_last;
      req_bit_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_readings.push_back(apply_request(op, data, mark_last, count));
   endtask

   // Compare one response beat with the oldest expectation
   task automatic check_reading();
      reading_type want;
      if (pending_readings.size() == 0) begin
         $error("response beat with no request outstanding");
         mismatches++;
      end else begin
         want = pending_readings.pop_front();
         if (rsp_field_bits !== want.field_bits) begin
            $error("field_bits: expected %h, got %h", want.field_bits, rsp_field_bits);
            mismatches++;
         end
         if (rsp_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status);
            mismatches++;
         end
         if (rsp_bit_position !== want.bit_position) begin
            $error("bit_position: expected %0d, got %0d", want.bit_position, rsp_bit_position);
            mismatches++;
         end
         if (rsp_bits_held !== want.bits_held) begin
            $error("bits_held: expected %0d, got %0d", want.bits_held, rsp_bits_held);
            mismatches++;
         end
      end
   endtask

   // Response side: check taken beats, then pick the next stall value
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_reading();
         if (hold_request_seq != hold_seen_seq) begin
            hold_seen_seq <= hold_request_seq;
            hold_left <= HOLD_OFF_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_gap_pct);
         end
      end
   end

   // Watchdog: too long without any beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic logic [5:0] random_count();
      return ($urandom_range(99) < 80) ? 6'($urandom_range(32)) : 6'($urandom_range(63));
   endfunction

   // Edge values, need-more, full refusal and count saturation, before the end mark
   task automatic test_directed_fields();
      send_item(bfr_pkg::OP_GET, 8'h00, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_SHOW, 8'h00, 1'b0, 6'd1);
      send_item(bfr_pkg::OP_FLUSH, 8'h00, 1'b0, 6'd5);
      send_item(bfr_pkg::OP_GET, 8'h00, 1'b0, 6'd63);
      send_item(bfr_pkg::OP_PUSH, 8'h00, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_PUSH, 8'hff, 1'b0, 6'd63);
      send_item(bfr_pkg::OP_PUSH, 8'ha5, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_PUSH, 8'h5a, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_PUSH, 8'h80, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_PUSH, 8'h01, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_PUSH, 8'hc3, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_PUSH, 8'h3c, 1'b0, 6'd0);
      // full accumulator: byte and its end mark both refused
      send_item(bfr_pkg::OP_PUSH, 8'h77, 1'b1, 6'd0);
      send_item(bfr_pkg::OP_SHOW, 8'h00, 1'b0, 6'd32);
      send_item(bfr_pkg::OP_GET, 8'h00, 1'b0, 6'd63);
      send_item(bfr_pkg::OP_FLUSH, 8'h00, 1'b0, 6'd33);
      send_item(bfr_pkg::OP_GET, 8'h00, 1'b0, 6'd0);
   endtask

   // Random requests before the end mark; fill level steered toward a moving target
   task automatic test_random_stream(int n_items);
      int              fill_target;
      int              roll;
      bfr_pkg::op_type op;
      logic [5:0]      count;
      fill_target = 0;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) fill_target = $urandom_range(bfr_pkg::ACC_BITS + 8);
         roll = $urandom_range(99);
         if (roll < 15) begin
            op = bfr_pkg::op_type'($urandom_range(3));
            count = 6'($urandom_range(63));
         end else if (held_model < fill_target) begin
            op = bfr_pkg::OP_PUSH;
            count = 6'($urandom_range(63));
         end else begin
            op = bfr_pkg::op_type'($urandom_range(3, 1));
            count = random_count();
         end
         // end mark only where the push will be refused
         send_item(op, 8'($urandom_range(255)),
                   (held_model + 8 > bfr_pkg::ACC_BITS) ? 1'($urandom_range(1)) : 1'b0,
                   count);
      end
   endtask

   // Response side holds off while requests keep coming, so the input stalls
   task automatic test_output_backpressure();
      hold_request_seq <= hold_request_seq + 1;
      test_random_stream(40);
   endtask

   // End mark, padding on short requests, pushes after the end
   task automatic test_end_of_stream();
      bfr_pkg::op_type op;
      if (held_model > 0)
         send_item(bfr_pkg::OP_FLUSH, 8'h00, 1'b0, 6'(held_model > 32 ? 32 : held_model));
      while (held_model > 0)
         send_item(bfr_pkg::OP_FLUSH, 8'h00, 1'b0, 6'(held_model > 32 ? 32 : held_model));
      send_item(bfr_pkg::OP_PUSH, 8'hff, 1'b1, 6'd0);
      send_item(bfr_pkg::OP_PUSH, 8'h81, 1'b0, 6'd0);
      send_item(bfr_pkg::OP_SHOW, 8'h00, 1'b0, 6'd20);
      send_item(bfr_pkg::OP_GET, 8'h00, 1'b0, 6'd32);
      send_item(bfr_pkg::OP_FLUSH, 8'h00, 1'b0, 6'd7);
      send_item(bfr_pkg::OP_GET, 8'h00, 1'b0, 6'd1);
      send_item(bfr_pkg::OP_PUSH, 8'h00, 1'b1, 6'd0);
      send_item(bfr_pkg::OP_GET, 8'h00, 1'b0, 6'd63);
      for (int i = 0; i < 240; i++) begin
         op = ($urandom_range(99) < 45) ? bfr_pkg::OP_PUSH :
              bfr_pkg::op_type'($urandom_range(3, 1));
         send_item(op, 8'($urandom_range(255)), 1'($urandom_range(1)), random_count());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_fields();
      test_random_stream(650);
      send_gap_pct = 67;
      recv_gap_pct <= 24;
      test_random_stream(650);
      send_gap_pct = 0;
      recv_gap_pct <= 0;
      test_output_backpressure();
      test_end_of_stream();
      // drain outstanding responses, then keep watching for stray responses
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### filelist.f
src/bfr_pkg.sv
src/bfr_front.sv
src/bfr_queue.sv
src/bfr_back.sv
src/bitstream_field_reader.sv
tb/testbench.sv
